[hw/rtl/ifb_pkg.sv]
// Shared types and constants for the 3x3 image filter bank.
// No dependencies; imported by the filter bank top level.
`default_nettype none

package ifb_pkg;

    localparam int PIX_W      = 8;
    localparam int VAL_W      = 16;
    localparam int ROW_W      = 16;
    localparam int COL_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd768;

    // ceil(2^19 / 9): floor(x * MEAN_RECIP / 2^19) == floor(x / 9) for x < 2^16
    localparam logic [15:0] MEAN_RECIP = 16'd58255;

    typedef enum logic [1:0] {
        FILT_GAUSS,
        FILT_MEAN,
        FILT_LAP,
        FILT_SOBEL
    } t_filt;

    // [row 0 top][col 0 left][pixel]
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    // which results an item produces
    typedef struct packed {
        logic first;   // centre one column left of the item
        logic second;  // row end: centre at the item's column
        logic flast;   // second result is the frame's last pixel
    } t_emit;

    // kernel sums ahead of the final abs / scale step
    typedef struct packed {
        logic signed [13:0] a;
        logic signed [10:0] b;
    } t_pre;

endpackage

`default_nettype wire

[hw/rtl/ifb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ifb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/image_3x3_filter_bank.sv]
// Throughput: one pixel per cycle unless held by o_in_stall; a row-end pixel yields two results,
//   shown one after the other on the single result port, which back-pressures the input.
// Line stores: one RAM entry per column holds {upper, middle}, read and written once a pixel.
// Reset (sync, active low) clears counters, window, pipeline valids and config to defaults;
//   the line-store RAM is not cleared and needs no clearing pass.
`default_nettype none

module image_3x3_filter_bank #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ifb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ifb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [ifb_pkg::PIX_W-1:0]         i_pixel,
    input  wire logic                              i_frame_start,
    // result output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [ifb_pkg::VAL_W-1:0]       o_filtered_value,
    output logic [ifb_pkg::COL_OUT_W-1:0]          o_out_col,
    output logic [ifb_pkg::ROW_W-1:0]              o_out_row,
    output logic                                   o_run_last,
    output logic                                   o_frame_last
);

    import ifb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);     // column index / RAM address
    localparam int WW = $clog2(MAX_WIDTH + 1); // holds a width up to MAX_WIDTH

    // ------------------------------------------------------------------
    // Kernel math: stage D forms sums, stage E does abs / scale / divide.
    // ------------------------------------------------------------------
    function automatic t_pre kern_pre(input t_win w, input t_filt sel);
        logic signed [13:0] p [3][3];
        logic signed [13:0] sum;
        logic signed [13:0] gauss;
        logic signed [13:0] gx;
        logic signed [13:0] gy;
        t_pre               res;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[i][j] = $signed({6'b0, w[i][j]});
            end
        end
        sum = p[0][0] + p[0][1] + p[0][2] + p[1][0] + p[1][1] + p[1][2]
            + p[2][0] + p[2][1] + p[2][2];
        gauss = p[0][0] + (p[0][1] <<< 1) + p[0][2]
              + (p[1][0] <<< 1) + (p[1][1] <<< 2) + (p[1][2] <<< 1)
              + p[2][0] + (p[2][1] <<< 1) + p[2][2];
        gx = (p[0][0] + (p[1][0] <<< 1) + p[2][0]) - (p[0][2] + (p[1][2] <<< 1) + p[2][2]);
        gy = (p[0][0] + (p[0][1] <<< 1) + p[0][2]) - (p[2][0] + (p[2][1] <<< 1) + p[2][2]);
        res.b = gy[10:0];
        case (sel)
            FILT_GAUSS: res.a = gauss;
            FILT_MEAN:  res.a = sum;
            FILT_LAP:   res.a = sum - (p[1][1] <<< 3) - p[1][1];
            default:    res.a = gx;
        endcase
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] kern_fin(input t_pre pr, input t_filt sel);
        logic [15:0]             x;
        logic [31:0]             prod;
        logic [10:0]             ax;
        logic [10:0]             ay;
        logic [11:0]             mag;
        logic signed [VAL_W-1:0] res;
        // mean: round-half-up of 16*s/9 equals floor((16*s + 4) / 9)
        x    = {pr.a[11:0], 4'b0100};
        prod = 32'(x) * 32'(MEAN_RECIP);
        ax   = pr.a[13] ? 11'(-pr.a) : pr.a[10:0];
        ay   = pr.b[10] ? 11'(-pr.b) : pr.b;
        mag  = {1'b0, ax} + {1'b0, ay};
        case (sel)
            FILT_GAUSS: res = VAL_W'(pr.a);
            FILT_MEAN:  res = {3'b0, prod[31:19]};
            FILT_LAP:   res = {pr.a[11:0], 4'b0};
            default:    res = {mag, 4'b0};
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    t_filt              r_sel;
    logic [WIDTH_W-1:0] r_width;
    logic [ROW_W-1:0]   r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= FILT_GAUSS;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_SELECT: r_sel    <= t_filt'(i_cfg_data[1:0]);
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[ROW_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // width 0 acts as 1, anything above MAX_WIDTH saturates; height 0 acts as 1
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? 16'd1 : r_height;
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next one is free.
    // ------------------------------------------------------------------
    logic r_b_valid, r_c_valid, r_d_valid;
    logic r_e_p1, r_e_p2;   // first / second result still to be shown
    t_emit r_d_emit;

    logic out_xfer, e_ready, d_fire, d_free, c_fire, c_free, b_fire, b_free, acc, e_load;

    assign out_xfer = o_out_valid && !i_out_stall;
    assign e_ready  = !(r_e_p1 || r_e_p2) || (out_xfer && !(r_e_p1 && r_e_p2));
    assign d_fire   = r_d_valid && (e_ready || !(r_d_emit.first || r_d_emit.second));
    assign e_load   = d_fire && (r_d_emit.first || r_d_emit.second);
    assign d_free   = !r_d_valid || d_fire;
    assign c_fire   = r_c_valid && d_free;
    assign c_free   = !r_c_valid || c_fire;
    assign b_fire   = r_b_valid && c_free;
    assign b_free   = !r_b_valid || b_fire;
    assign acc      = i_in_valid && b_free;

    assign o_in_stall = !b_free;

    // ------------------------------------------------------------------
    // Stage A: position counters, RAM read issue
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic [CW-1:0]    a_c0, a_c1, n_col;
    logic [ROW_W-1:0] a_r0, a_r1, a_r1w, a_rn, n_row;
    logic [WW-1:0]    a_cn;
    logic [PIX_W-1:0] a_cur;
    t_emit            a_emit;

    always_comb begin
        a_c0 = i_frame_start ? '0 : r_col;
        a_r0 = i_frame_start ? '0 : r_row;
        // counters left past a smaller size: end the row first
        if (WW'(a_c0) >= w_eff) begin
            a_c1  = '0;
            a_r1w = a_r0 + 16'd1;
        end else begin
            a_c1  = a_c0;
            a_r1w = a_r0;
        end
        a_r1  = (a_r1w > h_eff) ? '0 : a_r1w;
        // drain row reads as zero
        a_cur = (a_r1 < h_eff) ? i_pixel : '0;

        a_emit.first  = (a_r1 != '0) && (a_c1 != '0);
        a_emit.second = (a_r1 != '0) && (WW'(a_c1) == w_eff - WW'(1));
        a_emit.flast  = (a_r1 == h_eff);

        a_cn = WW'(a_c1) + WW'(1);
        a_rn = a_r1 + 16'd1;
        if (a_cn >= w_eff) begin
            n_col = '0;
            n_row = (a_rn > h_eff) ? '0 : a_rn;
        end else begin
            n_col = a_cn[CW-1:0];
            n_row = a_r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line-store RAM: entry = {upper, middle} for one column.
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] b_raw;
    logic [2*PIX_W-1:0] b_wdata;

    logic [CW-1:0]      r_b_col;
    logic [ROW_W-1:0]   r_b_row;
    logic               r_b_ge1, r_b_ge2;
    logic [PIX_W-1:0]   r_b_cur;
    t_emit              r_b_emit;
    logic               r_b_fwd;
    logic [2*PIX_W-1:0] r_b_fwd_data;

    ifb_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (b_fire),
        .i_waddr (r_b_col),
        .i_wdata (b_wdata),
        .i_re    (acc),
        .i_raddr (a_c1),
        .o_rdata (ram_q)
    );

    // same column written by stage B on the read edge: RAM returns stale data, so forward
    assign b_raw   = r_b_fwd ? r_b_fwd_data : ram_q;
    // upper takes the old middle, middle takes the new pixel
    assign b_wdata = {b_raw[PIX_W-1:0], r_b_cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_col      <= a_c1;
            r_b_row      <= a_r1 - 16'd1;
            r_b_ge1      <= (a_r1 != '0);
            r_b_ge2      <= (a_r1 > 16'd1);
            r_b_cur      <= a_cur;
            r_b_emit     <= a_emit;
            r_b_fwd      <= b_fire && (r_b_col == a_c1);
            r_b_fwd_data <= b_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage B -> C: window shift. Column 0 starts with a zero-padded left side.
    // ------------------------------------------------------------------
    t_win             r_win;
    logic [PIX_W-1:0] b_up, b_mid;
    logic [CW-1:0]    r_c_col;
    logic [ROW_W-1:0] r_c_row;
    t_emit            r_c_emit;

    assign b_up  = r_b_ge2 ? b_raw[2*PIX_W-1:PIX_W] : '0;
    assign b_mid = r_b_ge1 ? b_raw[PIX_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_c_valid <= 1'b0;
        end else begin
            if (b_fire) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_b_col == '0) begin
                        r_win[i][0] <= '0;
                        r_win[i][1] <= '0;
                    end else begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                end
                r_win[0][2] <= b_up;
                r_win[1][2] <= b_mid;
                r_win[2][2] <= r_b_cur;
                r_c_valid   <= 1'b1;
            end else if (c_fire) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_emit <= r_b_emit;
        end
    end

    // ------------------------------------------------------------------
    // Stage C -> D: kernel sums for the window and its right-edge variant
    // ------------------------------------------------------------------
    t_win             c_edge_win;
    logic [CW-1:0]    r_d_col;
    logic [ROW_W-1:0] r_d_row;
    t_pre             r_d_pre1, r_d_pre2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_edge_win[i][0] = r_win[i][1];
            c_edge_win[i][1] = r_win[i][2];
            c_edge_win[i][2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (c_fire) begin
            r_d_valid <= 1'b1;
        end else if (d_fire) begin
            r_d_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_d_col  <= r_c_col;
            r_d_row  <= r_c_row;
            r_d_emit <= r_c_emit;
            r_d_pre1 <= kern_pre(r_win, r_sel);
            r_d_pre2 <= kern_pre(c_edge_win, r_sel);
        end
    end

    // ------------------------------------------------------------------
    // Stage E: final values, output register shown one result at a time
    // ------------------------------------------------------------------
    logic [31:0]                 d_colx;
    logic [31:0]                 d_colm1;
    logic signed [VAL_W-1:0]     r_e_v1, r_e_v2;
    logic [COL_OUT_W-1:0]        r_e_col1, r_e_col2;
    logic [ROW_W-1:0]            r_e_row;
    logic                        r_e_rl1, r_e_fl;

    assign d_colx  = 32'(r_d_col);
    assign d_colm1 = d_colx - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_p1 <= 1'b0;
            r_e_p2 <= 1'b0;
        end else if (e_load) begin
            r_e_p1 <= r_d_emit.first;
            r_e_p2 <= r_d_emit.second;
        end else if (out_xfer) begin
            if (r_e_p1) begin
                r_e_p1 <= 1'b0;
            end else begin
                r_e_p2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_e_v1   <= kern_fin(r_d_pre1, r_sel);
            r_e_v2   <= kern_fin(r_d_pre2, r_sel);
            r_e_col1 <= d_colm1[COL_OUT_W-1:0];
            r_e_col2 <= d_colx[COL_OUT_W-1:0];
            r_e_row  <= r_d_row;
            r_e_rl1  <= !r_d_emit.second;
            r_e_fl   <= r_d_emit.flast;
        end
    end

    assign o_out_valid      = r_e_p1 || r_e_p2;
    assign o_filtered_value = r_e_p1 ? r_e_v1 : r_e_v2;
    assign o_out_col        = r_e_p1 ? r_e_col1 : r_e_col2;
    assign o_out_row        = r_e_row;
    assign o_run_last       = r_e_p1 ? r_e_rl1 : 1'b1;
    assign o_frame_last     = r_e_p1 ? 1'b0 : r_e_fl;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // frame end is only ever flagged on the row-end (last) result
    a_flast_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_run_last)
        else $error("frame_last without run_last");

    // a pixel's second result is held in the output register behind its first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last |=> o_out_valid && o_run_last)
        else $error("second result of a pixel lost");

    // an accepted pixel lands in the RAM-read stage
    a_accept_to_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_b_valid)
        else $error("accepted pixel dropped before line-store stage");

endmodule

`default_nettype wire
